[rtl/core/ssab_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssab_pkg: shared types and constants of the sprite sheet alpha blitter
// Operation and status codes, register indexes, configuration and command
// types used by the front, the command queue and the back.
// ----------------------------------------------------------------------------
package ssab_pkg;

    localparam int DEF_MAX_SHEET_WIDTH  = 256;
    localparam int DEF_MAX_SHEET_HEIGHT = 256;
    localparam int CMD_FIFO_DEPTH       = 4;
    localparam int CFG_ADDR_W           = 5;
    localparam int CFG_DATA_W           = 32;
    localparam int DIM_W                = 9;

    // Operation codes of an input item.
    localparam logic [1:0] OP_PIXEL = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Status codes of a result item.
    localparam logic [1:0] ST_WRITTEN = 2'd0;
    localparam logic [1:0] ST_CLIPPED = 2'd1;
    localparam logic [1:0] ST_READOUT = 2'd2;
    localparam logic [1:0] ST_STARTED = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_SHEET_WIDTH      = 3'd0;
    localparam logic [2:0] REG_SHEET_HEIGHT     = 3'd1;
    localparam logic [2:0] REG_SHEET_HAS_ALPHA  = 3'd2;
    localparam logic [2:0] REG_PASTE_X          = 3'd3;
    localparam logic [2:0] REG_PASTE_Y          = 3'd4;
    localparam logic [2:0] REG_PASTE_WIDTH      = 3'd5;
    localparam logic [2:0] REG_PASTE_HEIGHT     = 3'd6;
    localparam logic [2:0] REG_SOURCE_HAS_ALPHA = 3'd7;

    typedef struct packed {
        logic [DIM_W-1:0] sheet_width;
        logic [DIM_W-1:0] sheet_height;
        logic             sheet_has_alpha;
        logic [7:0]       paste_x;
        logic [7:0]       paste_y;
        logic [DIM_W-1:0] paste_width;
        logic [DIM_W-1:0] paste_height;
        logic             source_has_alpha;
    } t_cfg;

    // A note carries only a status; a read and a write touch the sheet store.
    typedef enum logic [1:0] {
        CK_NOTE  = 2'd0,
        CK_READ  = 2'd1,
        CK_WRITE = 2'd2
    } t_ckind;

    typedef struct packed {
        t_ckind     kind;
        logic [1:0] status;
        logic       blend;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_cmd;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

endpackage
`default_nettype wire

[rtl/core/ssab_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssab_front: input classification of the blitter
// Accepts items, tracks the source raster position, clips, and turns each
// item into a store command with its sheet address.
// ----------------------------------------------------------------------------
module ssab_front
    import ssab_pkg::*;
#(
    parameter int MAX_SHEET_WIDTH  = DEF_MAX_SHEET_WIDTH,
    parameter int MAX_SHEET_HEIGHT = DEF_MAX_SHEET_HEIGHT,
    parameter int ADDR_W           = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_hold,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire logic [1:0]        i_op,
    input  wire logic [7:0]        i_src_red,
    input  wire logic [7:0]        i_src_green,
    input  wire logic [7:0]        i_src_blue,
    input  wire logic [7:0]        i_src_alpha,
    input  wire logic [15:0]       i_read_index,
    input  wire logic              i_cmd_full,
    output logic                   o_cmd_push,
    output t_cmd                   o_cmd,
    output logic [ADDR_W-1:0]      o_cmd_addr
);

    typedef enum logic [1:0] {
        FK_START = 2'd0,
        FK_READ  = 2'd1,
        FK_PIXEL = 2'd2,
        FK_CLIP  = 2'd3
    } t_fkind;

    localparam int PROD_W = 2 * DIM_W;

    logic [DIM_W-1:0]  r_col, n_col;
    logic [DIM_W-1:0]  r_row, n_row;
    logic              r_valid, n_valid;
    t_fkind            r_kind, n_kind;
    logic [DIM_W-1:0]  r_x, n_x;
    logic [DIM_W-1:0]  r_y, n_y;
    logic [15:0]       r_idx, n_idx;
    logic [7:0]        r_red, n_red;
    logic [7:0]        r_green, n_green;
    logic [7:0]        r_blue, n_blue;
    logic [7:0]        r_sa, n_sa;
    logic              r_blend, n_blend;

    logic [DIM_W-1:0]  w_sw, w_sh, w_pw, w_ph;
    logic              w_acc, w_adv;
    logic [DIM_W:0]    w_x, w_y, w_col_inc;
    logic [DIM_W-1:0]  w_mul_a;
    logic [PROD_W-1:0] w_prod, w_sum;

    assign o_full     = i_hold || (r_valid && i_cmd_full);
    assign w_acc      = i_push && !o_full;
    assign w_adv      = r_valid && !i_cmd_full;
    assign o_cmd_push = w_adv;

    // Effective sheet and paste sizes.
    always_comb begin
        if (i_cfg.sheet_width == '0) begin
            w_sw = DIM_W'(1);
        end else if (32'(i_cfg.sheet_width) > MAX_SHEET_WIDTH) begin
            w_sw = DIM_W'(MAX_SHEET_WIDTH);
        end else begin
            w_sw = i_cfg.sheet_width;
        end
        if (i_cfg.sheet_height == '0) begin
            w_sh = DIM_W'(1);
        end else if (32'(i_cfg.sheet_height) > MAX_SHEET_HEIGHT) begin
            w_sh = DIM_W'(MAX_SHEET_HEIGHT);
        end else begin
            w_sh = i_cfg.sheet_height;
        end
        w_pw = (i_cfg.paste_width == '0) ? DIM_W'(1) : i_cfg.paste_width;
        w_ph = (i_cfg.paste_height == '0) ? DIM_W'(1) : i_cfg.paste_height;
    end

    always_comb begin
        w_x       = (DIM_W+1)'(i_cfg.paste_x) + (DIM_W+1)'(r_col);
        w_y       = (DIM_W+1)'(i_cfg.paste_y) + (DIM_W+1)'(r_row);
        w_col_inc = (DIM_W+1)'(r_col) + (DIM_W+1)'(1);

        n_col   = r_col;
        n_row   = r_row;
        n_valid = w_adv ? 1'b0 : r_valid;
        n_kind  = r_kind;
        n_x     = r_x;
        n_y     = r_y;
        n_idx   = r_idx;
        n_red   = r_red;
        n_green = r_green;
        n_blue  = r_blue;
        n_sa    = r_sa;
        n_blend = r_blend;

        if (w_acc) begin
            case (i_op)
                OP_START: begin
                    n_col   = '0;
                    n_row   = '0;
                    n_valid = 1'b1;
                    n_kind  = FK_START;
                end
                OP_READ: begin
                    n_valid = 1'b1;
                    n_kind  = FK_READ;
                    n_idx   = i_read_index;
                end
                OP_PIXEL: begin
                    n_valid = 1'b1;
                    n_red   = i_src_red;
                    n_green = i_src_green;
                    n_blue  = i_src_blue;
                    n_sa    = i_cfg.source_has_alpha ? i_src_alpha : 8'hFF;
                    n_blend = i_cfg.sheet_has_alpha;
                    n_x     = w_x[DIM_W-1:0];
                    n_y     = w_y[DIM_W-1:0];
                    if (r_row >= w_ph) begin
                        // Past the last row of the image: the raster holds.
                        n_kind = FK_CLIP;
                    end else begin
                        if (w_col_inc >= (DIM_W+1)'(w_pw)) begin
                            n_col = '0;
                            n_row = r_row + DIM_W'(1);
                        end else begin
                            n_col = w_col_inc[DIM_W-1:0];
                        end
                        if (w_x >= (DIM_W+1)'(w_sw) || w_y >= (DIM_W+1)'(w_sh)) begin
                            n_kind = FK_CLIP;
                        end else begin
                            n_kind = FK_PIXEL;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // One shared multiplier: sheet area for a readout, row offset for a pixel.
    always_comb begin
        w_mul_a = (r_kind == FK_READ) ? w_sh : r_y;
        w_prod  = PROD_W'(w_mul_a) * PROD_W'(w_sw);
        w_sum   = w_prod + PROD_W'(r_x);

        o_cmd.kind   = CK_NOTE;
        o_cmd.status = ST_CLIPPED;
        o_cmd.blend  = r_blend;
        o_cmd.red    = r_red;
        o_cmd.green  = r_green;
        o_cmd.blue   = r_blue;
        o_cmd.alpha  = r_sa;
        o_cmd_addr   = ADDR_W'(w_sum);
        case (r_kind)
            FK_START: begin
                o_cmd.status = ST_STARTED;
            end
            FK_READ: begin
                o_cmd.status = ST_READOUT;
                o_cmd_addr   = ADDR_W'(r_idx);
                if (PROD_W'(r_idx) < w_prod) begin
                    o_cmd.kind = CK_READ;
                end
            end
            FK_PIXEL: begin
                o_cmd.kind   = CK_WRITE;
                o_cmd.status = ST_WRITTEN;
            end
            default: begin
                o_cmd.status = ST_CLIPPED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_valid <= n_valid;
        end
        r_kind  <= n_kind;
        r_x     <= n_x;
        r_y     <= n_y;
        r_idx   <= n_idx;
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
        r_sa    <= n_sa;
        r_blend <= n_blend;
    end

endmodule
`default_nettype wire

[rtl/core/ssab_cmd_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssab_cmd_fifo: command queue between front and back
// A short first-in first-out queue of store commands.
// ----------------------------------------------------------------------------
module ssab_cmd_fifo
    import ssab_pkg::*;
#(
    parameter int DATA_W = 32,
    parameter int DEPTH  = CMD_FIFO_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic [DATA_W-1:0]      o_data,
    output logic                   o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              w_do_push, w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_do_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (w_do_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (w_do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

[rtl/core/ssab_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssab_back: sheet store and blend engine of the blitter
// Clears the sheet memory after reset, then runs each read or write command
// as a read-modify-write of one sheet pixel and holds every result for transfer.
// ----------------------------------------------------------------------------
module ssab_back
    import ssab_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_SHEET_WIDTH * DEF_MAX_SHEET_HEIGHT,
    parameter int ADDR_W = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cmd_empty,
    input  wire t_cmd              i_cmd,
    input  wire logic [ADDR_W-1:0] i_cmd_addr,
    output logic                   o_cmd_pop,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output logic [1:0]             o_status,
    output logic [31:0]            o_px,
    output t_back_stat             o_stat
);

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_MEM   = 2'd2,
        S_WB    = 2'd3
    } t_state;

    // d*(255-sa) + s*sa, at most 65025.
    function automatic logic [15:0] f_mix_sum(input logic [7:0] d, input logic [7:0] s,
                                              input logic [7:0] sa);
        logic [15:0] p0;
        logic [15:0] p1;
        p0 = 16'(d) * 16'(8'hFF - sa);
        p1 = 16'(s) * 16'(sa);
        return p0 + p1;
    endfunction

    // Exact floor(v/255) for any v up to 65025, the largest mix sum.
    function automatic logic [7:0] f_div255(input logic [15:0] v);
        logic [16:0] t;
        t = 17'(v) + 17'(v[15:8]) + 17'd1;
        return t[15:8];
    endfunction

    logic [31:0]       r_mem [DEPTH];
    logic [31:0]       r_rd_data;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic [ADDR_W-1:0] r_addr, n_addr;
    t_cmd              r_cmd, n_cmd;
    logic              r_do_blend, n_do_blend;
    logic [15:0]       r_sum_r, n_sum_r;
    logic [15:0]       r_sum_g, n_sum_g;
    logic [15:0]       r_sum_b, n_sum_b;
    logic [15:0]       r_sum_a, n_sum_a;
    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_out_status, n_out_status;
    logic [31:0]       r_out_px, n_out_px;

    logic              w_we, w_re, w_out_free;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    logic [31:0]       w_wdata;

    assign o_empty         = !r_out_valid;
    assign o_status        = r_out_status;
    assign o_px            = r_out_px;
    assign o_stat.clearing = (r_state == S_CLEAR);
    assign w_out_free      = !r_out_valid || i_pop;

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_addr       = r_addr;
        n_cmd        = r_cmd;
        n_do_blend   = r_do_blend;
        n_sum_r      = r_sum_r;
        n_sum_g      = r_sum_g;
        n_sum_b      = r_sum_b;
        n_sum_a      = r_sum_a;
        n_out_valid  = (r_out_valid && i_pop) ? 1'b0 : r_out_valid;
        n_out_status = r_out_status;
        n_out_px     = r_out_px;
        o_cmd_pop    = 1'b0;
        w_we         = 1'b0;
        w_waddr      = r_addr;
        w_wdata      = '0;
        w_re         = 1'b0;
        w_raddr      = i_cmd_addr;

        case (r_state)
            S_CLEAR: begin
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_cmd_empty && w_out_free) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_addr    = i_cmd_addr;
                    if (i_cmd.kind == CK_NOTE) begin
                        n_out_valid  = 1'b1;
                        n_out_status = i_cmd.status;
                        n_out_px     = '0;
                    end else begin
                        w_re    = 1'b1;
                        n_state = S_MEM;
                    end
                end
            end
            S_MEM: begin
                if (r_cmd.kind == CK_READ) begin
                    // Readout returns the pixel and clears it in the same pass.
                    w_we         = 1'b1;
                    n_out_valid  = 1'b1;
                    n_out_status = ST_READOUT;
                    n_out_px     = r_rd_data;
                    n_state      = S_IDLE;
                end else begin
                    n_do_blend = r_cmd.blend && (r_rd_data[31:24] != 8'h00);
                    n_sum_r    = f_mix_sum(r_rd_data[7:0], r_cmd.red, r_cmd.alpha);
                    n_sum_g    = f_mix_sum(r_rd_data[15:8], r_cmd.green, r_cmd.alpha);
                    n_sum_b    = f_mix_sum(r_rd_data[23:16], r_cmd.blue, r_cmd.alpha);
                    n_sum_a    = f_mix_sum(r_rd_data[31:24], 8'hFF, r_cmd.alpha);
                    n_state    = S_WB;
                end
            end
            S_WB: begin
                if (r_do_blend) begin
                    w_wdata = {f_div255(r_sum_a), f_div255(r_sum_b),
                               f_div255(r_sum_g), f_div255(r_sum_r)};
                end else begin
                    w_wdata = {r_cmd.alpha, r_cmd.blue, r_cmd.green, r_cmd.red};
                end
                w_we         = 1'b1;
                n_out_valid  = 1'b1;
                n_out_status = ST_WRITTEN;
                n_out_px     = w_wdata;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
        r_addr       <= n_addr;
        r_cmd        <= n_cmd;
        r_do_blend   <= n_do_blend;
        r_sum_r      <= n_sum_r;
        r_sum_g      <= n_sum_g;
        r_sum_b      <= n_sum_b;
        r_sum_a      <= n_sum_a;
        r_out_status <= n_out_status;
        r_out_px     <= n_out_px;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

endmodule
`default_nettype wire

[rtl/core/sprite_sheet_alpha_blitter_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_sheet_alpha_blitter_core: alpha blending blitter into a sheet store
// Source pixels pushed in raster order are clipped to the sheet and blended
// or copied into an RGBA sheet of MAX_SHEET_WIDTH*MAX_SHEET_HEIGHT words; a
// readout returns one sheet pixel and clears it. Every accepted item with an
// op of 0, 1 or 2 yields one result. The front takes an item per cycle while
// full is low into a four-entry command queue; the back, which owns the
// single-port sheet memory, runs a source pixel as a read, a multiply, and a
// divide with write back, a readout inside the sheet as a read and a clearing
// write, and a paste start, a clipped item or a readout outside the sheet
// from its idle state alone; it takes no new command until the last is done.
// After reset the back clears all MAX_SHEET_WIDTH*MAX_SHEET_HEIGHT words
// (65536 at the defaults), one word a cycle; full stays high during that
// pass, while configuration writes are taken as usual.
// ----------------------------------------------------------------------------
module sprite_sheet_alpha_blitter_core
    import ssab_pkg::*;
#(
    parameter int MAX_SHEET_WIDTH  = DEF_MAX_SHEET_WIDTH,
    parameter int MAX_SHEET_HEIGHT = DEF_MAX_SHEET_HEIGHT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [1:0]            i_op,
    input  wire logic [7:0]            i_src_red,
    input  wire logic [7:0]            i_src_green,
    input  wire logic [7:0]            i_src_blue,
    input  wire logic [7:0]            i_src_alpha,
    input  wire logic [15:0]           i_read_index,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [1:0]                 o_status,
    output logic [7:0]                 o_out_red,
    output logic [7:0]                 o_out_green,
    output logic [7:0]                 o_out_blue,
    output logic [7:0]                 o_out_alpha,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int STORE_DEPTH  = MAX_SHEET_WIDTH * MAX_SHEET_HEIGHT;
    localparam int STORE_ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CMD_W        = $bits(t_cmd) + STORE_ADDR_W;

    t_cfg                    r_cfg;
    logic [2:0]              w_reg_idx;
    logic                    w_cfg_we;

    logic                    w_cmd_push;
    t_cmd                    w_cmd;
    logic [STORE_ADDR_W-1:0] w_cmd_addr;
    logic                    w_fifo_full, w_fifo_empty, w_fifo_pop;
    logic [CMD_W-1:0]        w_fifo_rdata;
    t_back_stat              w_back_stat;
    logic [31:0]             w_px;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[CFG_ADDR_W-1:2];
    assign w_cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sheet_width      <= DIM_W'(256);
            r_cfg.sheet_height     <= DIM_W'(256);
            r_cfg.sheet_has_alpha  <= 1'b1;
            r_cfg.paste_x          <= 8'd0;
            r_cfg.paste_y          <= 8'd0;
            r_cfg.paste_width      <= DIM_W'(1);
            r_cfg.paste_height     <= DIM_W'(1);
            r_cfg.source_has_alpha <= 1'b1;
        end else if (w_cfg_we) begin
            case (w_reg_idx)
                REG_SHEET_WIDTH:      r_cfg.sheet_width      <= pwdata[DIM_W-1:0];
                REG_SHEET_HEIGHT:     r_cfg.sheet_height     <= pwdata[DIM_W-1:0];
                REG_SHEET_HAS_ALPHA:  r_cfg.sheet_has_alpha  <= pwdata[0];
                REG_PASTE_X:          r_cfg.paste_x          <= pwdata[7:0];
                REG_PASTE_Y:          r_cfg.paste_y          <= pwdata[7:0];
                REG_PASTE_WIDTH:      r_cfg.paste_width      <= pwdata[DIM_W-1:0];
                REG_PASTE_HEIGHT:     r_cfg.paste_height     <= pwdata[DIM_W-1:0];
                REG_SOURCE_HAS_ALPHA: r_cfg.source_has_alpha <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_SHEET_WIDTH:      prdata = CFG_DATA_W'(r_cfg.sheet_width);
            REG_SHEET_HEIGHT:     prdata = CFG_DATA_W'(r_cfg.sheet_height);
            REG_SHEET_HAS_ALPHA:  prdata = CFG_DATA_W'(r_cfg.sheet_has_alpha);
            REG_PASTE_X:          prdata = CFG_DATA_W'(r_cfg.paste_x);
            REG_PASTE_Y:          prdata = CFG_DATA_W'(r_cfg.paste_y);
            REG_PASTE_WIDTH:      prdata = CFG_DATA_W'(r_cfg.paste_width);
            REG_PASTE_HEIGHT:     prdata = CFG_DATA_W'(r_cfg.paste_height);
            REG_SOURCE_HAS_ALPHA: prdata = CFG_DATA_W'(r_cfg.source_has_alpha);
            default:              prdata = '0;
        endcase
    end

    ssab_front #(
        .MAX_SHEET_WIDTH  (MAX_SHEET_WIDTH),
        .MAX_SHEET_HEIGHT (MAX_SHEET_HEIGHT),
        .ADDR_W           (STORE_ADDR_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_hold       (w_back_stat.clearing),
        .i_push       (push),
        .o_full       (full),
        .i_op         (i_op),
        .i_src_red    (i_src_red),
        .i_src_green  (i_src_green),
        .i_src_blue   (i_src_blue),
        .i_src_alpha  (i_src_alpha),
        .i_read_index (i_read_index),
        .i_cmd_full   (w_fifo_full),
        .o_cmd_push   (w_cmd_push),
        .o_cmd        (w_cmd),
        .o_cmd_addr   (w_cmd_addr)
    );

    ssab_cmd_fifo #(
        .DATA_W (CMD_W),
        .DEPTH  (CMD_FIFO_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  ({w_cmd, w_cmd_addr}),
        .o_full  (w_fifo_full),
        .i_pop   (w_fifo_pop),
        .o_data  (w_fifo_rdata),
        .o_empty (w_fifo_empty)
    );

    ssab_back #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (STORE_ADDR_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (w_fifo_empty),
        .i_cmd       (t_cmd'(w_fifo_rdata[CMD_W-1:STORE_ADDR_W])),
        .i_cmd_addr  (w_fifo_rdata[STORE_ADDR_W-1:0]),
        .o_cmd_pop   (w_fifo_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_status    (o_status),
        .o_px        (w_px),
        .o_stat      (w_back_stat)
    );

    assign o_out_red   = w_px[7:0];
    assign o_out_green = w_px[15:8];
    assign o_out_blue  = w_px[23:16];
    assign o_out_alpha = w_px[31:24];

`ifndef NO_ASSERTIONS
    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_back_stat.clearing |-> full)
        else $error("input taken during the sheet clearing pass");

    a_clear_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_back_stat.clearing |-> empty)
        else $error("result offered during the sheet clearing pass");

    a_note_zero_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status == ST_CLIPPED || o_status == ST_STARTED))
        |-> ({o_out_alpha, o_out_blue, o_out_green, o_out_red} == 32'd0))
        else $error("clipped or paste-start result carries pixel data");

    a_no_queue_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_push |-> !w_fifo_full)
        else $error("command pushed into a full queue");
`endif

endmodule
`default_nettype wire

[tb/tb_sprite_sheet_alpha_blitter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sprite_sheet_alpha_blitter_core: self-checking bench of the blitter core
// Pushes paste starts, raster-order source pixels, readouts and unused ops,
// predicts each result from a private copy of the sheet store and the paste
// counters, and checks every popped result in order. Configuration is written
// and read back over APB between phases, once every expected result is popped.
// ----------------------------------------------------------------------------
module tb_sprite_sheet_alpha_blitter_core;
    import ssab_pkg::*;

    localparam int          LIMIT_CYCLES  = 600000;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          RANDOM_ITEMS  = 1400;
    localparam int          SHEET_WORDS   = DEF_MAX_SHEET_WIDTH * DEF_MAX_SHEET_HEIGHT;
    localparam logic [1:0]  OP_UNUSED     = 2'd3;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } blit_result_t;

    typedef enum logic [1:0] {
        RX_STREAM,
        RX_COIN,
        RX_MOSTLY
    } rx_mode_t;

    class blit_scoreboard;
        bit [31:0]      sheet_mem [0:SHEET_WORDS-1];
        int unsigned    src_col;
        int unsigned    src_row;
        logic [8:0]     sheet_w;
        logic [8:0]     sheet_h;
        logic [8:0]     paste_w;
        logic [8:0]     paste_h;
        logic [7:0]     paste_x;
        logic [7:0]     paste_y;
        logic           sheet_alpha;
        logic           src_alpha_en;
        blit_result_t   expected_q [$];
        int unsigned    mismatches;
        int unsigned    checked;

        function new();
            src_col      = 0;
            src_row      = 0;
            sheet_w      = 9'd256;
            sheet_h      = 9'd256;
            sheet_alpha  = 1'b1;
            paste_x      = 8'd0;
            paste_y      = 8'd0;
            paste_w      = 9'd1;
            paste_h      = 9'd1;
            src_alpha_en = 1'b1;
            mismatches   = 0;
            checked      = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_SHEET_WIDTH:      sheet_w      = value[8:0];
                REG_SHEET_HEIGHT:     sheet_h      = value[8:0];
                REG_SHEET_HAS_ALPHA:  sheet_alpha  = value[0];
                REG_PASTE_X:          paste_x      = value[7:0];
                REG_PASTE_Y:          paste_y      = value[7:0];
                REG_PASTE_WIDTH:      paste_w      = value[8:0];
                REG_PASTE_HEIGHT:     paste_h      = value[8:0];
                default:              src_alpha_en = value[0];
            endcase
        endfunction

        function logic [31:0] reg_value(logic [2:0] idx);
            case (idx)
                REG_SHEET_WIDTH:     return {23'd0, sheet_w};
                REG_SHEET_HEIGHT:    return {23'd0, sheet_h};
                REG_SHEET_HAS_ALPHA: return {31'd0, sheet_alpha};
                REG_PASTE_X:         return {24'd0, paste_x};
                REG_PASTE_Y:         return {24'd0, paste_y};
                REG_PASTE_WIDTH:     return {23'd0, paste_w};
                REG_PASTE_HEIGHT:    return {23'd0, paste_h};
                default:             return {31'd0, src_alpha_en};
            endcase
        endfunction

        // Out-of-range sheet sizes saturate to 1..max.
        function int unsigned eff_width();
            if (sheet_w == 0) return 1;
            if (sheet_w > DEF_MAX_SHEET_WIDTH) return DEF_MAX_SHEET_WIDTH;
            return sheet_w;
        endfunction

        function int unsigned eff_height();
            if (sheet_h == 0) return 1;
            if (sheet_h > DEF_MAX_SHEET_HEIGHT) return DEF_MAX_SHEET_HEIGHT;
            return sheet_h;
        endfunction

        function bit [7:0] blend_channel(int unsigned dst, int unsigned src, int unsigned sa);
            return 8'((dst * (255 - sa) + src * sa) / 255);
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%s", msg);
        endfunction

        function void note_item(logic [1:0] op, logic [7:0] r, logic [7:0] g,
                                logic [7:0] b, logic [7:0] a, logic [15:0] idx);
            blit_result_t res;
            int unsigned  sw;
            int unsigned  sh;
            int unsigned  pw;
            int unsigned  ph;
            int unsigned  sa;
            int unsigned  x;
            int unsigned  y;
            int unsigned  addr;
            bit [31:0]    px;
            sw  = eff_width();
            sh  = eff_height();
            pw  = (paste_w == 0) ? 1 : paste_w;
            ph  = (paste_h == 0) ? 1 : paste_h;
            res = '0;
            case (op)
                OP_START: begin
                    src_col    = 0;
                    src_row    = 0;
                    res.status = ST_STARTED;
                end
                OP_READ: begin
                    res.status = ST_READOUT;
                    if (idx < sw * sh) begin
                        px             = sheet_mem[idx];
                        sheet_mem[idx] = '0;
                        {res.alpha, res.blue, res.green, res.red} = px;
                    end
                end
                OP_PIXEL: begin
                    sa         = src_alpha_en ? a : 255;
                    res.status = ST_CLIPPED;
                    // Once the image's last row is done, pixels clip and the
                    // counters stay where they are.
                    if (src_row < ph) begin
                        x = paste_x + src_col;
                        y = paste_y + src_row;
                        src_col++;
                        if (src_col >= pw) begin
                            src_col = 0;
                            src_row++;
                        end
                        if (x < sw && y < sh) begin
                            addr = y * sw + x;
                            px   = sheet_mem[addr];
                            if (sheet_alpha && px[31:24] != 0) begin
                                res.red   = blend_channel(px[7:0], r, sa);
                                res.green = blend_channel(px[15:8], g, sa);
                                res.blue  = blend_channel(px[23:16], b, sa);
                                res.alpha = blend_channel(px[31:24], 255, sa);
                            end else begin
                                res.red   = r;
                                res.green = g;
                                res.blue  = b;
                                res.alpha = 8'(sa);
                            end
                            res.status      = ST_WRITTEN;
                            sheet_mem[addr] = {res.alpha, res.blue, res.green, res.red};
                        end
                    end
                end
                default: return;
            endcase
            expected_q.push_back(res);
        endfunction

        function void check_result(blit_result_t got);
            blit_result_t want;
            checked++;
            if (expected_q.size() == 0) begin
                note_mismatch($sformatf("result %0d: no item pending, got status %0d",
                                        checked, got.status));
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status || got.red !== want.red ||
                got.green !== want.green || got.blue !== want.blue ||
                got.alpha !== want.alpha)
                note_mismatch($sformatf(
                    "result %0d: expected status %0d rgba %h %h %h %h, got status %0d rgba %h %h %h %h",
                    checked, want.status, want.red, want.green, want.blue, want.alpha,
                    got.status, got.red, got.green, got.blue, got.alpha));
        endfunction

        function void check_register(logic [2:0] idx, logic [31:0] got);
            if (got !== reg_value(idx))
                note_mismatch($sformatf("register %0d: expected %h, got %h",
                                        idx, reg_value(idx), got));
        endfunction
    endclass

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  push         = 1'b0;
    logic                  full;
    logic [1:0]            i_op         = OP_PIXEL;
    logic [7:0]            i_src_red    = '0;
    logic [7:0]            i_src_green  = '0;
    logic [7:0]            i_src_blue   = '0;
    logic [7:0]            i_src_alpha  = '0;
    logic [15:0]           i_read_index = '0;
    logic                  empty;
    logic                  pop          = 1'b0;
    logic [1:0]            o_status;
    logic [7:0]            o_out_red;
    logic [7:0]            o_out_green;
    logic [7:0]            o_out_blue;
    logic [7:0]            o_out_alpha;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr        = '0;
    logic [CFG_DATA_W-1:0] pwdata       = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    blit_scoreboard sb;
    int unsigned    burst_left = 0;
    int unsigned    stall_left = 0;
    int unsigned    mode_left  = 0;
    rx_mode_t       rx_mode    = RX_STREAM;
    int unsigned    cycle_count = 0;

    sprite_sheet_alpha_blitter_core u_top (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: check each transfer, then choose pop for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            sb.check_result({o_status, o_out_red, o_out_green, o_out_blue, o_out_alpha});
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            pop <= 1'b0;
        end else begin
            case (rx_mode)
                RX_STREAM: pop <= 1'b1;
                RX_COIN:   pop <= 1'($urandom_range(0, 1));
                default:   pop <= ($urandom_range(0, 3) != 0);
            endcase
            if ($urandom_range(0, 47) == 0) stall_left = $urandom_range(1, 20);
        end
        if (mode_left == 0) begin
            rx_mode   = rx_mode_t'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic [7:0] a,
                             input logic [15:0] idx);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap != 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        push         <= 1'b1;
        i_op         <= op;
        i_src_red    <= r;
        i_src_green  <= g;
        i_src_blue   <= b;
        i_src_alpha  <= a;
        i_read_index <= idx;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_item(op, r, g, b, a, idx);
        burst_left--;
    endtask

    // Holds the sender off until every expected result has been popped.
    task automatic drain();
        push       <= 1'b0;
        burst_left  = 0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.write_reg(idx, value);
    endtask

    task automatic apb_check(input logic [2:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.check_register(idx, prdata);
    endtask

    // Drains every expected result, then writes and reads back every register.
    task automatic load_config(input logic [8:0] sw, input logic [8:0] sh,
                               input logic sha, input logic [7:0] px, input logic [7:0] py,
                               input logic [8:0] pw, input logic [8:0] ph, input logic srca);
        logic [31:0] vals [0:7];
        int          i;
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        vals[REG_SHEET_WIDTH]      = {23'd0, sw};
        vals[REG_SHEET_HEIGHT]     = {23'd0, sh};
        vals[REG_SHEET_HAS_ALPHA]  = {31'd0, sha};
        vals[REG_PASTE_X]          = {24'd0, px};
        vals[REG_PASTE_Y]          = {24'd0, py};
        vals[REG_PASTE_WIDTH]      = {23'd0, pw};
        vals[REG_PASTE_HEIGHT]     = {23'd0, ph};
        vals[REG_SOURCE_HAS_ALPHA] = {31'd0, srca};
        for (i = 0; i < 8; i++) apb_write(3'(i), vals[i]);
        for (i = 0; i < 8; i++) apb_check(3'(i));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [8:0] pick_sheet_dim();
        case ($urandom_range(0, 7))
            0:       return 9'd0;
            1:       return 9'd1;
            2:       return 9'd256;
            3:       return 9'($urandom_range(257, 511));
            4:       return 9'($urandom_range(1, 256));
            default: return 9'($urandom_range(2, 16));
        endcase
    endfunction

    function automatic logic [8:0] pick_paste_dim();
        case ($urandom_range(0, 9))
            0:       return 9'd0;
            1:       return 9'd256;
            2:       return 9'($urandom_range(257, 511));
            default: return 9'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [7:0] pick_offset();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom);
            default: return 8'($urandom_range(0, 10));
        endcase
    endfunction

    function automatic logic [7:0] rand_channel();
        case ($urandom_range(0, 4))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        logic [8:0]  sw;
        logic [8:0]  sh;
        logic [8:0]  pw;
        logic [8:0]  ph;
        logic [7:0]  px;
        logic [7:0]  py;
        int unsigned pw_eff;
        int unsigned ph_eff;
        int unsigned npix;
        int unsigned k;
        int unsigned idx;
        int unsigned phase_items;
        int unsigned sent;
        int unsigned random_total;

        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A 4x3 blending sheet, a 3-wide image at (2,1) whose zero height acts
        // as one row; the third column falls off the right edge.
        load_config(9'd4, 9'd3, 1'b1, 8'd2, 8'd1, 9'd3, 9'd0, 1'b1);
        send_item(OP_START, 8'hff, 8'hff, 8'hff, 8'hff, 16'hffff);
        send_item(OP_PIXEL, 8'hff, 8'h00, 8'hff, 8'h00, 16'h0000);
        send_item(OP_PIXEL, 8'h00, 8'hff, 8'h00, 8'hff, 16'hffff);
        send_item(OP_PIXEL, 8'h55, 8'haa, 8'h55, 8'haa, 16'h0000);
        send_item(OP_PIXEL, 8'h12, 8'h34, 8'h56, 8'h78, 16'h0000);
        send_item(OP_START, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
        send_item(OP_PIXEL, 8'd10, 8'd20, 8'd30, 8'd200, 16'h0000);
        send_item(OP_PIXEL, 8'hff, 8'hff, 8'hff, 8'd128, 16'h0000);
        send_item(OP_PIXEL, 8'h01, 8'h01, 8'h01, 8'h01, 16'h0000);
        send_item(OP_START, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
        send_item(OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
        send_item(OP_PIXEL, 8'd1, 8'd2, 8'd3, 8'hff, 16'h0000);
        send_item(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 16'd7);
        send_item(OP_READ, 8'hff, 8'hff, 8'hff, 8'hff, 16'd7);
        send_item(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 16'd6);
        send_item(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 16'd11);
        send_item(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 16'd12);
        send_item(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 16'hffff);
        send_item(OP_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff, 16'd6);

        // Oversized width saturates to 256 and zero height to one row; a
        // plain copy into an RGB sheet from an RGB source writes alpha 255.
        load_config(9'd511, 9'd0, 1'b0, 8'd255, 8'd0, 9'd2, 9'd2, 1'b0);
        send_item(OP_START, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
        send_item(OP_PIXEL, 8'h80, 8'h40, 8'h20, 8'h00, 16'h0000);
        send_item(OP_PIXEL, 8'h80, 8'h40, 8'h20, 8'h00, 16'h0000);
        send_item(OP_PIXEL, 8'h01, 8'h02, 8'h03, 8'h04, 16'h0000);
        send_item(OP_PIXEL, 8'h01, 8'h02, 8'h03, 8'h04, 16'h0000);
        send_item(OP_PIXEL, 8'h01, 8'h02, 8'h03, 8'h04, 16'h0000);
        send_item(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 16'd255);
        send_item(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 16'd256);

        random_total = 0;
        while (random_total < RANDOM_ITEMS) begin
            sw = pick_sheet_dim();
            sh = pick_sheet_dim();
            px = pick_offset();
            py = pick_offset();
            pw = pick_paste_dim();
            ph = pick_paste_dim();
            load_config(sw, sh, ($urandom_range(0, 3) != 0), px, py, pw, ph,
                        ($urandom_range(0, 9) < 7));
            pw_eff      = (pw == 0) ? 1 : pw;
            ph_eff      = (ph == 0) ? 1 : ph;
            phase_items = $urandom_range(60, 140);
            sent        = 0;
            while (sent < phase_items) begin
                send_item(OP_START, 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), 16'($urandom));
                sent++;
                npix = pw_eff * ph_eff;
                if (npix > 48 && $urandom_range(0, 3) != 0) npix = $urandom_range(1, 48);
                if (npix > 300) npix = 300;
                npix += $urandom_range(0, 2);
                for (k = 0; k < npix; k++) begin
                    case ($urandom_range(0, 63))
                        0: begin
                            // Restart in the middle of an image.
                            send_item(OP_START, 8'($urandom), 8'($urandom), 8'($urandom),
                                      8'($urandom), 16'($urandom));
                            sent++;
                        end
                        1, 2: send_item(OP_UNUSED, 8'($urandom), 8'($urandom),
                                        8'($urandom), 8'($urandom), 16'($urandom));
                        3, 4, 5, 6, 7, 8, 9: begin
                            case ($urandom_range(0, 3))
                                0:       idx = $urandom_range(0, 65535);
                                1:       idx = $urandom_range(0, sb.eff_width() *
                                                              sb.eff_height() - 1);
                                default: idx = (py + $urandom_range(0, ph_eff - 1)) *
                                               sb.eff_width() + px +
                                               $urandom_range(0, pw_eff - 1);
                            endcase
                            send_item(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom),
                                      8'($urandom), 16'(idx));
                            sent++;
                        end
                        10: drain();
                        default: ;
                    endcase
                    send_item(OP_PIXEL, rand_channel(), rand_channel(), rand_channel(),
                              rand_channel(), 16'($urandom));
                    sent++;
                end
            end
            random_total += sent;
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sprite_sheet_alpha_blitter_core.f]
rtl/core/ssab_pkg.sv
rtl/core/ssab_front.sv
rtl/core/ssab_cmd_fifo.sv
rtl/core/ssab_back.sv
rtl/core/sprite_sheet_alpha_blitter_core.sv
tb/tb_sprite_sheet_alpha_blitter_core.sv
